// ----- hw/rtl/ibfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ibfr_pkg
// Shared constants for the iBUS frame receiver.
// ----------------------------------------------------------------------------
package ibfr_pkg;

  localparam logic [7:0]  Hdr0        = 8'h20;
  localparam logic [7:0]  Hdr1        = 8'h40;
  localparam int          FrameLen    = 32;
  localparam int          MaxChannels = 14;
  localparam int          FrameWords  = FrameLen / 2;
  localparam int          WordAw      = $clog2(FrameWords);
  localparam int          PosW        = $clog2(FrameLen);
  localparam logic [15:0] SumInit     = 16'hFFFF - {8'h00, Hdr0} - {8'h00, Hdr1};

endpackage

// ----- hw/rtl/ibus_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// ibus_frame_receiver
// iBUS frame decoder: header hunt, 32-byte frame capture, checksum check,
// held channel update and one item per channel at frame end.
// ----------------------------------------------------------------------------
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------------------
//   rx      | rx_valid  | rx_stall  | rx_byte
//   result  | res_valid | res_stall | channel_index, channel_value,
//           |           |           | checksum_ok, last
//
// The byte that ends a frame starts a burst of CHANNELS items, each through
// a read of the frame and held-channel RAMs, a write-back and output load,
// and a handshake that waits while res_stall is high. rx_stall stays high
// for the whole burst. Synchronous reset clears the header hunt and marks
// every held channel as zero.
// ----------------------------------------------------------------------------
module ibus_frame_receiver
  import ibfr_pkg::*;
#(
  parameter int CHANNELS = MaxChannels
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [3:0]  channel_index,
  output logic [15:0] channel_value,
  output logic        checksum_ok,
  output logic        last
);

  localparam int HeldAw = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_WR   = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t         state;
  logic [PosW-1:0] pos;
  logic [7:0]     lo_byte;
  logic [15:0]    calc;
  logic           ok;
  logic [3:0]     ch;
  logic [CHANNELS-1:0] held_vld;

  logic           rx_acc;
  logic           res_acc;
  logic           ch_last;
  logic [HeldAw-1:0] held_idx;

  logic           frm_we;
  logic [WordAw-1:0] frm_waddr;
  logic [WordAw-1:0] frm_raddr;
  logic [15:0]    frm_rdata;
  logic           held_we;
  logic [15:0]    held_rdata;
  logic [15:0]    value_next;

  assign rx_stall = (state != S_IDLE);
  assign rx_acc   = rx_valid && !rx_stall;
  assign res_acc  = res_valid && !res_stall;
  assign ch_last  = (ch == 4'(CHANNELS - 1));
  assign held_idx = ch[HeldAw-1:0];

  // frame words 1..14 hold the channel words
  assign frm_we    = rx_acc && (pos >= PosW'(2)) && pos[0];
  assign frm_waddr = pos[PosW-1:1];
  assign frm_raddr = WordAw'(ch) + WordAw'(1);

  ibfr_ram #(.Width(16), .Depth(FrameWords)) u_frame_ram (
    .clk   (clk),
    .we    (frm_we),
    .waddr (frm_waddr),
    .wdata ({rx_byte, lo_byte}),
    .raddr (frm_raddr),
    .rdata (frm_rdata)
  );

  assign held_we = (state == S_WR) && ok;

  ibfr_ram #(.Width(16), .Depth(CHANNELS)) u_held_ram (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_idx),
    .wdata (frm_rdata),
    .raddr (held_idx),
    .rdata (held_rdata)
  );

  always_comb begin
    if (ok) begin
      value_next = frm_rdata;
    end else if (held_vld[held_idx]) begin
      value_next = held_rdata;
    end else begin
      value_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      ch        <= '0;
      held_vld  <= '0;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (rx_acc) begin
            if (pos == PosW'(0)) begin
              if (rx_byte == Hdr0) begin
                pos <= PosW'(1);
              end
            end else if (pos == PosW'(1)) begin
              pos  <= (rx_byte == Hdr1) ? PosW'(2) : PosW'(0);
              calc <= SumInit;
            end else begin
              pos <= pos + PosW'(1);
              if (pos < PosW'(30)) begin
                calc <= calc - {8'h00, rx_byte};
              end
              if (!pos[0]) begin
                lo_byte <= rx_byte;
              end
              if (pos == PosW'(FrameLen - 1)) begin
                ok    <= (calc == {rx_byte, lo_byte});
                ch    <= '0;
                state <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (ok) begin
            held_vld[held_idx] <= 1'b1;
          end
          channel_index <= ch;
          channel_value <= value_next;
          checksum_ok   <= ok;
          last          <= ch_last;
          res_valid     <= 1'b1;
          state         <= S_OUT;
        end
        S_OUT: begin
          if (!res_stall) begin
            res_valid <= 1'b0;
            if (ch_last) begin
              state <= S_IDLE;
            end else begin
              ch    <= ch + 4'd1;
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_res_in_out: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> state == S_OUT)
    else $error("result valid outside output state");

  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    ch <= 4'(CHANNELS - 1))
    else $error("channel counter out of range");

  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    (res_acc && last) |=> !rx_stall)
    else $error("rx not released after last item");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (rx_acc && pos == PosW'(FrameLen - 1)) |=> (state == S_RD && ch == 4'd0))
    else $error("burst not started at frame end");

  a_pos_hunt: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> pos == PosW'(0))
    else $error("byte position not cleared during burst");

endmodule

// ----- hw/rtl/ibfr_ram.sv -----
// ----------------------------------------------------------------------------
// ibfr_ram
// Generic RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ibfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [Aw-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic [Aw-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
